FILE: rtl/core/tmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types, register indexes and helpers of the trapezoidal motion profile.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int DATA_W    = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DECEL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd3;

  // configuration reset values, Q16.16
  localparam logic [CFG_W-1:0] RST_MAX_SPEED   = 31'd65536;
  localparam logic [CFG_W-1:0] RST_MAX_ACCEL   = 31'd65536;
  localparam logic [CFG_W-1:0] RST_MAX_DECEL   = 31'd65536;
  localparam logic [CFG_W-1:0] RST_TICK_PERIOD = 31'd655;

  // command kinds
  localparam logic OP_SPEED    = 1'b0;
  localparam logic OP_POSITION = 1'b1;

  // last iteration indexes of the shared divider and square root
  localparam logic [5:0] DIV_LAST  = 6'd48;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  typedef struct packed {
    logic [CFG_W-1:0] tick_period;
    logic [CFG_W-1:0] max_decel;
    logic [CFG_W-1:0] max_accel;
    logic [CFG_W-1:0] max_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_accel;
    logic signed [DATA_W-1:0] new_speed;
    logic signed [DATA_W-1:0] new_position;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CORR, ST_VC, ST_VC2, ST_PROD, ST_SUM, ST_SQRT, ST_DVSET, ST_DVDT,
    ST_DIV, ST_CHK, ST_FALL, ST_LIM, ST_ASTEP, ST_DSTEP, ST_WIN, ST_NV, ST_NVDT,
    ST_POS, ST_ACC, ST_DONE
  } state_t;

  // saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tmp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_core
// Tick sequencer around one multiplier, a radix-2 divider and a bit-pair root.
// ----------------------------------------------------------------------------
module tmp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  tmp_pkg::cfg_t        cfg,
  input  logic                 start,
  input  logic                 op,
  input  logic signed [31:0]   tspd,
  input  logic signed [31:0]   tpos,
  output logic                 idle,
  output logic                 res_valid,
  input  logic                 res_take,
  output tmp_pkg::res_t        res
);

  tmp_pkg::state_t state, state_next, ret;

  // architectural state
  logic signed [31:0] speed_reg, position_reg, accel_reg;

  // working registers
  logic [30:0]        dt;
  logic               d_neg;
  logic [32:0]        ad;
  logic [31:0]        w;
  logic [30:0]        corr;
  logic [31:0]        vc;
  logic [63:0]        rad;
  logic [64:0]        prod;
  logic [31:0]        root;
  logic [33:0]        srem;
  logic [5:0]         cnt;
  logic [49:0]        dv;
  logic [31:0]        decel;
  logic signed [32:0] wanted;
  logic [45:0]        astep;
  logic signed [49:0] lo, hi;
  logic signed [31:0] nv;
  logic signed [32:0] diff;
  logic [48:0]        div_num;
  logic [30:0]        div_rem;
  logic signed [31:0] npos;

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  logic        prod_en;

  // datapath intermediates
  logic signed [32:0] d_in;
  logic [47:0]        corr_raw;
  logic [30:0]        corr_c;
  logic [65:0]        sum66;
  logic [35:0]        rem2, trial;
  logic               sq_ge;
  logic [31:0]        r2;
  logic               div_ge;
  logic               chk_cond;
  logic [30:0]        lim;
  logic signed [49:0] v50, dstep50, astep50, vm50, lo_w, hi_w, wv;
  logic signed [49:0] nsel;
  logic signed [31:0] nv_c;
  logic [32:0]        nv_mag, dmag;
  logic signed [63:0] pm, sterm, np;
  logic signed [49:0] acc50;

  assign idle      = (state == tmp_pkg::ST_IDLE);
  assign res_valid = (state == tmp_pkg::ST_DONE);
  assign res       = '{new_accel: accel_reg, new_speed: speed_reg, new_position: position_reg};

  // multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    prod_en = 1'b1;
    unique case (state)
      tmp_pkg::ST_CORR:  begin mul_a = {2'b0, cfg.max_decel}; mul_b = {1'b0, dt}; end
      tmp_pkg::ST_VC2:   begin mul_a = {1'b0, vc};            mul_b = vc;           end
      tmp_pkg::ST_PROD:  begin mul_a = ad;                    mul_b = {1'b0, cfg.max_decel}; end
      tmp_pkg::ST_DVDT:  begin mul_a = {1'b0, dv[31:0]};      mul_b = {1'b0, dt}; end
      tmp_pkg::ST_ASTEP: begin mul_a = {2'b0, cfg.max_accel}; mul_b = {1'b0, dt}; end
      tmp_pkg::ST_DSTEP: begin mul_a = {1'b0, decel};         mul_b = {1'b0, dt}; end
      tmp_pkg::ST_NVDT:  begin mul_a = nv_mag;                mul_b = {1'b0, dt}; end
      default:           prod_en = 1'b0;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // combinational datapath pieces
  always_comb begin
    d_in     = {tpos[31], tpos} - {position_reg[31], position_reg};
    corr_raw = prod[64:17];
    corr_c   = (|corr_raw[47:31]) ? 31'h7fffffff : corr_raw[30:0];
    sum66    = {2'b0, rad} + {prod, 1'b0};
    rem2     = {srem, rad[63:62]};
    trial    = {2'b0, root, 2'b01};
    sq_ge    = (rem2 >= trial);
    r2       = {div_rem, div_num[48]};
    div_ge   = (r2 >= {1'b0, dt});
    chk_cond = (prod[64:16] > {16'b0, ad}) && (div_num < {17'b0, cfg.max_decel, 1'b0});
    lim      = (dv < {19'b0, cfg.max_speed}) ? dv[30:0] : cfg.max_speed;
    // speed window around the current speed
    v50      = {{18{speed_reg[31]}}, speed_reg};
    dstep50  = {3'b0, prod[62:16]};
    astep50  = {4'b0, astep};
    vm50     = {19'b0, cfg.max_speed};
    if (!speed_reg[31]) begin
      lo_w = v50 - dstep50;
      hi_w = v50 + astep50;
    end else begin
      lo_w = v50 - astep50;
      hi_w = v50 + dstep50;
    end
    if (lo_w < -vm50) lo_w = -vm50;
    if (hi_w > vm50)  hi_w = vm50;
    // clamp wanted speed, lower bound first
    wv = {{17{wanted[32]}}, wanted};
    priority if (wv < lo)      nsel = lo;
    else if (wv > hi)          nsel = hi;
    else                       nsel = wv;
    nv_c   = tmp_pkg::sat32({{14{nsel[49]}}, nsel});
    nv_mag = nv[31] ? 33'(-{nv[31], nv}) : {1'b0, nv};
    dmag   = diff[32] ? 33'(-diff) : diff;
    // position step, floor of v*dt
    pm     = {2'b0, prod[61:0]};
    sterm  = nv[31] ? ((-pm) >>> 16) : (pm >>> 16);
    np     = {{32{position_reg[31]}}, position_reg} + sterm;
    acc50  = diff[32] ? -$signed({1'b0, div_num}) : $signed({1'b0, div_num});
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmp_pkg::ST_IDLE:  if (start) state_next = (op == tmp_pkg::OP_POSITION) ?
                                     tmp_pkg::ST_CORR : tmp_pkg::ST_ASTEP;
      tmp_pkg::ST_CORR:  state_next = tmp_pkg::ST_VC;
      tmp_pkg::ST_VC:    state_next = tmp_pkg::ST_VC2;
      tmp_pkg::ST_VC2:   state_next = tmp_pkg::ST_PROD;
      tmp_pkg::ST_PROD:  state_next = tmp_pkg::ST_SUM;
      tmp_pkg::ST_SUM:   state_next = tmp_pkg::ST_SQRT;
      tmp_pkg::ST_SQRT:  if (cnt == '0) state_next = tmp_pkg::ST_DVSET;
      tmp_pkg::ST_DVSET: state_next = tmp_pkg::ST_DVDT;
      tmp_pkg::ST_DVDT:  state_next = tmp_pkg::ST_DIV;
      tmp_pkg::ST_DIV:   if (cnt == '0) state_next = ret;
      tmp_pkg::ST_CHK:   state_next = chk_cond ? tmp_pkg::ST_DIV : tmp_pkg::ST_LIM;
      tmp_pkg::ST_FALL:  state_next = tmp_pkg::ST_LIM;
      tmp_pkg::ST_LIM:   state_next = tmp_pkg::ST_ASTEP;
      tmp_pkg::ST_ASTEP: state_next = tmp_pkg::ST_DSTEP;
      tmp_pkg::ST_DSTEP: state_next = tmp_pkg::ST_WIN;
      tmp_pkg::ST_WIN:   state_next = tmp_pkg::ST_NV;
      tmp_pkg::ST_NV:    state_next = tmp_pkg::ST_NVDT;
      tmp_pkg::ST_NVDT:  state_next = tmp_pkg::ST_POS;
      tmp_pkg::ST_POS:   state_next = tmp_pkg::ST_DIV;
      tmp_pkg::ST_ACC:   state_next = tmp_pkg::ST_DONE;
      tmp_pkg::ST_DONE:  if (res_take) state_next = tmp_pkg::ST_IDLE;
      default:           state_next = tmp_pkg::ST_IDLE;
    endcase
  end

  // architectural state, updated once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_reg    <= '0;
      position_reg <= '0;
      accel_reg    <= '0;
    end else if (state == tmp_pkg::ST_ACC) begin
      speed_reg    <= nv;
      position_reg <= npos;
      accel_reg    <= tmp_pkg::sat32({{14{acc50[49]}}, acc50});
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (prod_en) prod <= mul_p;
    unique case (state)
      tmp_pkg::ST_IDLE: begin
        dt     <= (cfg.tick_period == '0) ? 31'd1 : cfg.tick_period;
        d_neg  <= d_in[32];
        ad     <= d_in[32] ? 33'(-d_in) : d_in;
        w      <= tspd[31] ? 32'(-tspd) : tspd;
        wanted <= {tspd[31], tspd};
        decel  <= {1'b0, cfg.max_decel};
      end
      tmp_pkg::ST_VC: begin
        corr <= corr_c;
        vc   <= w + {1'b0, corr_c};
      end
      tmp_pkg::ST_PROD: rad <= prod[63:0];
      tmp_pkg::ST_SUM: begin
        rad  <= (|sum66[65:64]) ? '1 : sum66[63:0];
        root <= '0;
        srem <= '0;
        cnt  <= tmp_pkg::SQRT_LAST;
      end
      // one result bit per cycle
      tmp_pkg::ST_SQRT: begin
        if (sq_ge) begin
          srem <= 34'(rem2 - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          srem <= rem2[33:0];
          root <= {root[30:0], 1'b0};
        end
        rad <= {rad[61:0], 2'b00};
        cnt <= cnt - 6'd1;
      end
      tmp_pkg::ST_DVSET: dv <= {18'b0, root - {1'b0, corr}};
      tmp_pkg::ST_DVDT: begin
        div_num <= {1'b0, dv[31:0], 16'b0};
        div_rem <= '0;
        cnt     <= tmp_pkg::DIV_LAST;
        ret     <= tmp_pkg::ST_CHK;
      end
      // restoring divide, one quotient bit per cycle
      tmp_pkg::ST_DIV: begin
        div_rem <= div_ge ? 31'(r2 - {1'b0, dt}) : r2[30:0];
        div_num <= {div_num[47:0], div_ge};
        cnt     <= cnt - 6'd1;
      end
      // low-speed overshoot fallback
      tmp_pkg::ST_CHK: begin
        if (chk_cond) begin
          decel   <= {cfg.max_decel, 1'b0};
          div_num <= {ad, 16'b0};
          div_rem <= '0;
          cnt     <= tmp_pkg::DIV_LAST;
          ret     <= tmp_pkg::ST_FALL;
        end
      end
      tmp_pkg::ST_FALL: dv <= {18'b0, w} + {1'b0, div_num};
      tmp_pkg::ST_LIM:  wanted <= d_neg ? -$signed({2'b0, lim}) : $signed({2'b0, lim});
      tmp_pkg::ST_DSTEP: astep <= prod[61:16];
      tmp_pkg::ST_WIN: begin
        lo <= lo_w;
        hi <= hi_w;
      end
      tmp_pkg::ST_NV: begin
        nv   <= nv_c;
        diff <= {nv_c[31], nv_c} - {speed_reg[31], speed_reg};
      end
      tmp_pkg::ST_POS: begin
        npos    <= tmp_pkg::sat32(np);
        div_num <= {dmag, 16'b0};
        div_rem <= '0;
        cnt     <= tmp_pkg::DIV_LAST;
        ret     <= tmp_pkg::ST_ACC;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/trapezoidal_motion_profile_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile_top
// One control tick per input transfer: speed or position command, Q16.16.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tuser: op; tdata: target_speed, target_position
//  m_*      out  tdata: new_position, new_speed, new_accel
//  cfg_*    in   write enable, index 0..3, 31-bit data
//
// A position command runs the 32-step square root and a 49-step divide before
// the speed steps, and a second divide when the low-speed fallback runs; every
// command ends in an acceleration divide. s_tready is high only while the
// sequencer is idle; a finished result waits in the output register.
// rst is synchronous and loads the register reset values and zero state.
module trapezoidal_motion_profile_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // target_speed, target_position
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // new_position, new_speed, new_accel
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  tmp_pkg::cfg_t cfg;
  tmp_pkg::res_t res;
  logic          idle, res_valid, res_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed   <= tmp_pkg::RST_MAX_SPEED;
      cfg.max_accel   <= tmp_pkg::RST_MAX_ACCEL;
      cfg.max_decel   <= tmp_pkg::RST_MAX_DECEL;
      cfg.tick_period <= tmp_pkg::RST_TICK_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmp_pkg::REG_MAX_SPEED:   cfg.max_speed   <= cfg_data;
        tmp_pkg::REG_MAX_ACCEL:   cfg.max_accel   <= cfg_data;
        tmp_pkg::REG_MAX_DECEL:   cfg.max_decel   <= cfg_data;
        tmp_pkg::REG_TICK_PERIOD: cfg.tick_period <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = idle;
  assign res_take = !m_tvalid || m_tready;

  tmp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (s_tvalid && s_tready),
    .op        (s_tuser),
    .tspd      (s_tdata[31:0]),
    .tpos      (s_tdata[63:32]),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) m_tdata <= res;
  end

endmodule

FILE: rtl/core/tmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_checker
// Port-level checks of the motion profile block, bound to the top level.
// ----------------------------------------------------------------------------
module tmp_port_assert (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  // after reset the block is empty and ready
  a_reset: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  // an input transfer takes the block out of ready while the tick runs
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after input transfer");

  // a new result appears only as the sequencer returns to idle
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result shown while busy");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind trapezoidal_motion_profile_top tmp_port_assert u_tmp_port_assert (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/tmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_checker
// Watches the configuration port and both streams of the trapezoidal motion
// profile, predicts every tick result in Q16.16 and compares it field by field.
// ----------------------------------------------------------------------------
module tmp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          pending_ticks
);

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // shadow configuration and motion state
  logic [63:0] speed_lim, accel_lim, decel_lim, period;
  logic signed [31:0] cur_speed, cur_pos, cur_accel;
  tmp_pkg::res_t expected_ticks[$];

  function automatic longint clamp_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // q16.16 product rounded toward minus infinity
  function automatic longint mul_floor(longint a, logic [63:0] b);
    logic [63:0] m;
    if (a >= 0) return longint'((64'(a) * b) >> 16);
    m = 64'(-a) * b;
    return -longint'((m + 64'd65535) >> 16);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] eff_period();
    return (period == 0) ? 64'd1 : period;
  endfunction

  // clamp the wanted speed to the accel/decel window and advance the tick
  function automatic void speed_tick(longint wanted, logic [63:0] decel);
    logic [63:0] dt;
    longint v, astep, dstep, lo, hi, nv, acc, np, vm;
    dt = eff_period();
    v = longint'(cur_speed);
    astep = longint'((accel_lim * dt) >> 16);
    dstep = longint'((decel * dt) >> 16);
    vm = longint'(speed_lim);
    if (v >= 0) begin
      lo = v - dstep;
      hi = v + astep;
    end else begin
      lo = v - astep;
      hi = v + dstep;
    end
    if (lo < -vm) lo = -vm;
    if (hi > vm) hi = vm;
    nv = wanted;
    if (nv < lo) nv = lo;
    else if (nv > hi) nv = hi;
    nv = clamp_s32(nv);
    acc = ((nv - v) * 64'sd65536) / longint'(dt);
    np = longint'(cur_pos) + mul_floor(nv, dt);
    cur_accel = 32'(clamp_s32(acc));
    cur_speed = 32'(nv);
    cur_pos = 32'(clamp_s32(np));
  endfunction

  // deceleration ramp limit toward the target position
  function automatic void position_tick(longint tpos, longint tspd);
    logic [63:0] dt, ad, w, corr, vc, vc2, p, s, dv, decel;
    longint d, lim;
    dt = eff_period();
    d = tpos - longint'(cur_pos);
    ad = 64'((d < 0) ? -d : d);
    w = 64'((tspd < 0) ? -tspd : tspd);
    corr = (decel_lim * dt) >> 17;
    decel = decel_lim;
    if (corr > 64'd2147483647) corr = 64'd2147483647;
    vc = w + corr;
    vc2 = vc * vc;
    p = ad * decel_lim;
    if (p > (ALL_ONES - vc2) / 2) s = ALL_ONES;
    else s = vc2 + 2 * p;
    dv = root_floor(s) - corr;
    // low-speed overshoot fallback
    if (((dv * dt) >> 16) > ad && ((dv << 16) / dt) < 2 * decel_lim) begin
      dv = w + (ad << 16) / dt;
      decel = 2 * decel_lim;
    end
    lim = (dv < speed_lim) ? longint'(dv) : longint'(speed_lim);
    if (d < 0) lim = -lim;
    speed_tick(lim, decel);
  endfunction

  always @(posedge clk) begin
    tmp_pkg::res_t got, want;
    if (rst) begin
      speed_lim = 64'(tmp_pkg::RST_MAX_SPEED);
      accel_lim = 64'(tmp_pkg::RST_MAX_ACCEL);
      decel_lim = 64'(tmp_pkg::RST_MAX_DECEL);
      period = 64'(tmp_pkg::RST_TICK_PERIOD);
      cur_speed = 0;
      cur_pos = 0;
      cur_accel = 0;
      expected_ticks.delete();
    end else begin
      // result transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = tmp_pkg::res_t'(m_tdata);
        if (expected_ticks.size() == 0) begin
          $display("%0t: result with no tick pending: %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          if (got.new_position !== want.new_position) begin
            $display("%0t: new_position expected %0d actual %0d", $time,
                     want.new_position, got.new_position);
            fail_count++;
          end
          if (got.new_speed !== want.new_speed) begin
            $display("%0t: new_speed expected %0d actual %0d", $time,
                     want.new_speed, got.new_speed);
            fail_count++;
          end
          if (got.new_accel !== want.new_accel) begin
            $display("%0t: new_accel expected %0d actual %0d", $time,
                     want.new_accel, got.new_accel);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          tmp_pkg::REG_MAX_SPEED:   speed_lim = 64'(cfg_data);
          tmp_pkg::REG_MAX_ACCEL:   accel_lim = 64'(cfg_data);
          tmp_pkg::REG_MAX_DECEL:   decel_lim = 64'(cfg_data);
          tmp_pkg::REG_TICK_PERIOD: period = 64'(cfg_data);
        endcase
      end
      // command transfer: advance the shadow state
      if (s_tvalid && s_tready) begin
        if (s_tuser == tmp_pkg::OP_POSITION)
          position_tick(longint'($signed(s_tdata[63:32])), longint'($signed(s_tdata[31:0])));
        else
          speed_tick(longint'($signed(s_tdata[31:0])), decel_lim);
        want.new_position = cur_pos;
        want.new_speed = cur_speed;
        want.new_accel = cur_accel;
        expected_ticks.push_back(want);
      end
    end
    pending_ticks = expected_ticks.size();
  end

  initial begin
    fail_count = 0;
    pending_ticks = 0;
  end

endmodule

FILE: verif/tb_trapezoidal_motion_profile_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trapezoidal_motion_profile_top
// Drives speed and position commands through several limit settings, with
// bursty input and a stalling result side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_trapezoidal_motion_profile_top;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // target_speed, target_position
  logic        s_tuser = 0;    // op
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [95:0] m_tdata;        // new_position, new_speed, new_accel
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  int fail_count, pending_ticks;
  int burst_left = 0;
  int stall_mode = 0;
  logic signed [31:0] last_pos = 0;

  trapezoidal_motion_profile_top dut (.*);

  tmp_checker chk (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // result side stall pattern
  always @(negedge clk) begin
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) last_pos <= m_tdata[31:0];
  end

  initial begin
    #10_000_000;
    $display("trapezoidal_motion_profile_top regression: fail");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic set_limits(logic [30:0] spd, logic [30:0] acc, logic [30:0] dec,
                            logic [30:0] dt);
    write_reg(tmp_pkg::REG_MAX_SPEED, spd);
    write_reg(tmp_pkg::REG_MAX_ACCEL, acc);
    write_reg(tmp_pkg::REG_MAX_DECEL, dec);
    write_reg(tmp_pkg::REG_TICK_PERIOD, dt);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one command transfer, bursts separated by random gaps
  task automatic send_tick(logic op, logic [31:0] spd, logic [31:0] pos);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {pos, spd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
  endtask

  // let every pending result drain before touching the limits
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_ticks != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_tick();
    logic op;
    logic [31:0] spd, pos;
    op = $urandom_range(0, 1) ? tmp_pkg::OP_POSITION : tmp_pkg::OP_SPEED;
    if ($urandom_range(0, 3) == 0) spd = $urandom;
    else spd = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    if ($urandom_range(0, 3) == 0) pos = $urandom;
    else pos = last_pos + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    send_tick(op, spd, pos);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset limits, field extremes, both commands
    stall_mode = 0;
    send_tick(tmp_pkg::OP_SPEED, 32'h7fffffff, 32'h0);
    send_tick(tmp_pkg::OP_SPEED, 32'h80000000, 32'hffffffff);
    send_tick(tmp_pkg::OP_SPEED, 32'h0, 32'h80000000);
    send_tick(tmp_pkg::OP_POSITION, 32'h0, 32'h00100000);
    send_tick(tmp_pkg::OP_POSITION, 32'h0, 32'h00000010);
    send_tick(tmp_pkg::OP_POSITION, 32'h80000000, 32'h80000000);
    send_tick(tmp_pkg::OP_POSITION, 32'h7fffffff, 32'h7fffffff);
    drain();
    // all limits at their top: huge correction and saturated radicand
    set_limits(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_tick(tmp_pkg::OP_POSITION, 32'h7fffffff, 32'h7fffffff);
    send_tick(tmp_pkg::OP_SPEED, 32'h80000000, 32'h0);
    send_tick(tmp_pkg::OP_SPEED, 32'h7fffffff, 32'h0);
    send_tick(tmp_pkg::OP_POSITION, 32'h80000000, 32'h80000000);
    send_tick(tmp_pkg::OP_SPEED, 32'h0, 32'h0);
    drain();
    // zero tick period acts as one lsb
    set_limits(31'd1 << 20, 31'd1 << 24, 31'd1 << 24, 31'd0);
    send_tick(tmp_pkg::OP_SPEED, 32'h00080000, 32'h0);
    send_tick(tmp_pkg::OP_POSITION, 32'h0, 32'hfff00000);
    send_tick(tmp_pkg::OP_POSITION, 32'h0, 32'h00000001);
    drain();
    // speed beyond a narrowed max_speed, then zero limits
    set_limits(31'd1000, 31'd65536, 31'd65536, 31'd655);
    send_tick(tmp_pkg::OP_SPEED, 32'h7fffffff, 32'h0);
    send_tick(tmp_pkg::OP_POSITION, 32'h0, 32'h7fffffff);
    drain();
    set_limits(31'd0, 31'd0, 31'd0, 31'd1);
    send_tick(tmp_pkg::OP_SPEED, 32'h7fffffff, 32'h0);
    send_tick(tmp_pkg::OP_POSITION, 32'h1234, 32'h80000000);
    drain();

    // random phases, each under fresh limits
    for (int ph = 0; ph < 9; ph++) begin
      stall_mode = $urandom_range(0, 2);
      if (ph == 0)
        set_limits(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      else if (ph == 1)
        set_limits(31'd0, 31'd0, 31'd0, 31'd1);
      else
        set_limits(31'($urandom_range(0, 1 << 24)), 31'($urandom_range(0, 1 << 26)),
                   31'($urandom_range(0, 1 << 26)), 31'($urandom_range(1, 1 << 16)));
      repeat (100) random_tick();
      drain();
    end

    repeat (250) @(posedge clk);
    if (fail_count == 0 && pending_ticks == 0) begin
      $display("trapezoidal_motion_profile_top regression: pass");
    end else begin
      $display("trapezoidal_motion_profile_top regression: fail");
    end
    $finish;
  end

endmodule
